// ===== rtl/core/ultrasonic_echo_ranger_top_assert.svh =====
// Assertion macros used by the ultrasonic echo ranger sequencer.
`ifndef ULTRASONIC_ECHO_RANGER_TOP_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define UER_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: %m");
`define UER_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: %m");
`else
`define UER_ASSERT_IMP(lbl, ante, cons)
`define UER_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/core/uer_pkg.sv =====
// Package with the types, constants and register codes of the echo ranger.
package uer_pkg;

    localparam int COUNT_BITS_DEF = 20;
    localparam int PHASE_BITS_DEF = 16;

    localparam int TICK_W     = 16;
    localparam int DIST_W     = 18;
    localparam int ECHO_W     = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 48;
    localparam int Q_DEPTH    = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_PRE_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST   = 3'd4;

    localparam logic [TICK_W-1:0] PRE_LOW_RST    = 16'd160;
    localparam logic [TICK_W-1:0] PULSE_HIGH_RST = 16'd96;
    localparam logic [TICK_W-1:0] POST_LOW_RST   = 16'd160;
    localparam logic [TICK_W-1:0] SCALE_RST      = 16'd35678;
    localparam logic [DIST_W-1:0] MAX_DIST_RST   = 18'd128000;

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_PRE   = 6'b000010,
        PH_HIGH  = 6'b000100,
        PH_POST  = 6'b001000,
        PH_WAIT  = 6'b010000,
        PH_COUNT = 6'b100000
    } phase_t;

    typedef struct packed {
        logic start_req;
        logic echo_level;
    } item_t;

    typedef struct packed {
        logic [TICK_W-1:0] pre_low_ticks;
        logic [TICK_W-1:0] pulse_high_ticks;
        logic [TICK_W-1:0] post_low_ticks;
        logic [TICK_W-1:0] scale_q16;
        logic [DIST_W-1:0] max_distance_q8;
    } cfg_t;

    typedef struct packed {
        logic              trigger_level;
        logic              busy_res;
        logic              done_res;
        logic [DIST_W-1:0] distance_q8;
        logic              held_previous;
        logic [ECHO_W-1:0] echo_ticks;
    } result_t;

endpackage

// ===== rtl/core/uer_front.sv =====
// Input side: accepts items, decodes their fields and queues them for the sequencer.
module uer_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [uer_pkg::IN_DATA_W-1:0] s_axis_tdata,
    output uer_pkg::item_t                item,
    output logic                          item_valid,
    input  logic                          item_pop
);
    import uer_pkg::*;

    localparam int AW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    item_t          q_mem_reg [Q_DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  cnt_next;
    logic           push;
    item_t          in_item;

    assign s_axis_tready = (cnt_reg != CW'(Q_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign in_item       = '{start_req: s_axis_tdata[0], echo_level: s_axis_tdata[1]};
    assign item_valid    = (cnt_reg != '0);
    assign item          = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !item_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && item_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (item_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== rtl/core/uer_back.sv =====
// Measurement sequencer: trigger phases, echo timing, distance and the output register.
`include "ultrasonic_echo_ranger_top_assert.svh"

module uer_back #(
    parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF,
    parameter int PHASE_BITS = uer_pkg::PHASE_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  uer_pkg::cfg_t    cfg,
    input  uer_pkg::item_t   item,
    input  logic             item_valid,
    output logic             item_pop,
    output uer_pkg::result_t res,
    output logic             res_valid,
    input  logic             res_ready
);
    import uer_pkg::*;

    localparam int PROD_W = COUNT_BITS + TICK_W;
    localparam int CMP_W  = (PHASE_BITS > TICK_W) ? PHASE_BITS : TICK_W;
    localparam int DW     = (COUNT_BITS > DIST_W) ? COUNT_BITS : DIST_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [PHASE_BITS-1:0] PHASE_MAX = '1;

    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [PHASE_BITS-1:0]  ticks_reg;
    logic [PHASE_BITS-1:0]  ticks_next;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [COUNT_BITS-1:0]  count_next;
    logic [PROD_W-1:0]      prod_reg;
    logic [PROD_W-1:0]      prod_next;
    logic [DIST_W-1:0]      dist_reg;
    logic [DIST_W-1:0]      dist_next;
    logic                   out_valid_reg;
    result_t                res_reg;
    result_t                res_next;

    logic                   step;
    logic [PHASE_BITS-1:0]  ticks_inc;
    logic [TICK_W-1:0]      cur_len;
    logic                   phase_end;
    phase_t                 after_high;
    phase_t                 after_pre;
    phase_t                 first_phase;
    logic [DW-1:0]          dist_full;
    logic                   over;
    logic                   done;
    logic                   held;
    logic                   pre_echo;

    assign step      = item_valid && (!out_valid_reg || res_ready);
    assign item_pop  = step;
    assign res       = res_reg;
    assign res_valid = out_valid_reg;

    assign ticks_inc   = ticks_reg + 1'b1;
    assign after_high  = (cfg.post_low_ticks != '0) ? PH_POST : PH_WAIT;
    assign after_pre   = (cfg.pulse_high_ticks != '0) ? PH_HIGH : after_high;
    assign first_phase = (cfg.pre_low_ticks != '0) ? PH_PRE : after_pre;
    assign dist_full   = DW'(prod_reg[PROD_W-1:TICK_W]);
    assign over        = dist_full > DW'(cfg.max_distance_q8);
    assign pre_echo    = (phase_reg == PH_PRE) || (phase_reg == PH_HIGH) ||
                         (phase_reg == PH_POST) || (phase_reg == PH_WAIT);

    always_comb
    begin
        unique case (phase_reg)
            PH_PRE:  cur_len = cfg.pre_low_ticks;
            PH_HIGH: cur_len = cfg.pulse_high_ticks;
            default: cur_len = cfg.post_low_ticks;
        endcase
    end

    assign phase_end = (CMP_W'(ticks_inc) >= CMP_W'(cur_len)) || (ticks_inc == PHASE_MAX);

    always_comb
    begin
        phase_next = phase_reg;
        ticks_next = ticks_reg;
        count_next = count_reg;
        prod_next  = prod_reg;
        dist_next  = dist_reg;
        done       = 1'b0;
        held       = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (item.start_req)
                begin
                    count_next = '0;
                    prod_next  = '0;
                    phase_next = first_phase;
                    ticks_next = '0;
                end
            end
            PH_PRE, PH_HIGH, PH_POST:
            begin
                ticks_next = ticks_inc;
                if (phase_end)
                begin
                    ticks_next = '0;
                    if (phase_reg == PH_PRE)
                    begin
                        phase_next = after_pre;
                    end
                    else if (phase_reg == PH_HIGH)
                    begin
                        phase_next = after_high;
                    end
                    else
                    begin
                        phase_next = PH_WAIT;
                    end
                end
            end
            PH_WAIT:
            begin
                if (item.echo_level)
                begin
                    count_next = COUNT_BITS'(1);
                    prod_next  = PROD_W'(cfg.scale_q16);
                    phase_next = PH_COUNT;
                end
            end
            PH_COUNT:
            begin
                if (item.echo_level)
                begin
                    if (count_reg != COUNT_MAX)
                    begin
                        count_next = count_reg + 1'b1;
                        prod_next  = prod_reg + PROD_W'(cfg.scale_q16);
                    end
                end
                else
                begin
                    held       = over;
                    dist_next  = over ? dist_reg : dist_full[DIST_W-1:0];
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                    ticks_next = '0;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                ticks_next = '0;
            end
        endcase
    end

    always_comb
    begin
        res_next.trigger_level = (phase_reg == PH_HIGH);
        res_next.busy_res      = (phase_next != PH_IDLE);
        res_next.done_res      = done;
        res_next.distance_q8   = dist_next;
        res_next.held_previous = held;
        res_next.echo_ticks    = ECHO_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            ticks_reg     <= '0;
            count_reg     <= '0;
            prod_reg      <= '0;
            dist_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                phase_reg     <= phase_next;
                ticks_reg     <= ticks_next;
                count_reg     <= count_next;
                prod_reg      <= prod_next;
                dist_reg      <= dist_next;
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    `UER_ASSERT_IMP(a_held_only_on_done, res_valid && res.held_previous, res.done_res)
    `UER_ASSERT_IMP(a_done_ends_run, res_valid && res.done_res, !res.busy_res && !res.trigger_level)
    `UER_ASSERT_IMP(a_count_clear_before_echo, pre_echo, count_reg == '0)
    `UER_ASSERT_NXT(a_fall_reports_done, step && phase_reg == PH_COUNT && !item.echo_level, res_valid && res.done_res)

endmodule

// ===== rtl/core/ultrasonic_echo_ranger_top.sv =====
// Top level of the ultrasonic echo ranger: configuration registers, input queue and sequencer.
//
// Each input item is one 8 MHz timer tick and produces exactly one result item. The block
// takes one item per clock cycle for as long as the output side keeps up; an item's result
// passes through the four-entry input queue and then the sequencer's output register. The
// sequencer advances the measurement by one tick per accepted item and keeps the echo
// distance as a running sum of the scale factor, so no multiplier sits in the loop. When the
// output stalls the queue fills and input ready drops once the queue holds four items.
// Configuration is written through a plain write port and should only change while no
// measurement is running.
module ultrasonic_echo_ranger_top #(
    parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF,
    parameter int PHASE_BITS = uer_pkg::PHASE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // Fields from bit 0: start_req, echo_level, zero fill.
    input  logic [uer_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // Fields from bit 0: trigger_level, busy_res, done_res, distance_q8,
    // held_previous, echo_ticks, zero fill.
    output logic [uer_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                           cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data
);
    import uer_pkg::*;

    localparam int RES_W = $bits(result_t);

    cfg_t    cfg_reg;
    item_t   item;
    logic    item_valid;
    logic    item_pop;
    result_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pre_low_ticks    <= PRE_LOW_RST;
            cfg_reg.pulse_high_ticks <= PULSE_HIGH_RST;
            cfg_reg.post_low_ticks   <= POST_LOW_RST;
            cfg_reg.scale_q16        <= SCALE_RST;
            cfg_reg.max_distance_q8  <= MAX_DIST_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PRE_LOW:    cfg_reg.pre_low_ticks    <= cfg_data[TICK_W-1:0];
                CFG_PULSE_HIGH: cfg_reg.pulse_high_ticks <= cfg_data[TICK_W-1:0];
                CFG_POST_LOW:   cfg_reg.post_low_ticks   <= cfg_data[TICK_W-1:0];
                CFG_SCALE:      cfg_reg.scale_q16        <= cfg_data[TICK_W-1:0];
                CFG_MAX_DIST:   cfg_reg.max_distance_q8  <= cfg_data[DIST_W-1:0];
                default:        cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    uer_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .item          (item),
        .item_valid    (item_valid),
        .item_pop      (item_pop)
    );

    uer_back #(
        .COUNT_BITS (COUNT_BITS),
        .PHASE_BITS (PHASE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .res        (res),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {
        (OUT_DATA_W - RES_W)'(0),
        res.echo_ticks,
        res.held_previous,
        res.distance_q8,
        res.done_res,
        res.busy_res,
        res.trigger_level
    };

endmodule
